// ===== rtl/ssi_pkg.sv =====
// Shared types and constants for the sorted scoreboard with increment.
package ssi_pkg;

  localparam int unsigned ID_W    = 4;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned POS_W   = 5;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_PLACE,
    ST_DONE
  } ssi_state_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } ssi_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // input transfer: check position, read its entry
    logic load;    // capture credited entry, read the rank above
    logic shift;   // move the rank above down one, read the next one up
    logic place;   // write credited entry at its final rank
  } ssi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_ok;   // requested position addresses an entry
    logic p_zero;   // current rank is the head
    logic p_one;    // current rank is just below the head
    logic nb_less;  // entry above scores strictly lower than credited entry
  } ssi_status_t;

endpackage

// ===== rtl/ssi_ctrl.sv =====
// Controller state machine for the sorted scoreboard with increment.
module ssi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ssi_pkg::ssi_status_t status_i,
  output ssi_pkg::ssi_cmd_t    cmd_o
);
  import ssi_pkg::*;

  ssi_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.pos_ok ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        state_d = status_i.p_zero ? ST_PLACE : ST_CMP;
      end
      ST_CMP: begin
        if (status_i.nb_less && !status_i.p_one) begin
          state_d = ST_CMP;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_LOAD:  cmd_o.load = 1'b1;
      ST_CMP:   cmd_o.shift = status_i.nb_less;
      ST_PLACE: cmd_o.place = 1'b1;
      ST_DONE:  out_valid_o = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/ssi_dpath.sv =====
// Datapath: ranked table memory, credited entry, rank pointer and result registers.
module ssi_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssi_pkg::ssi_cmd_t             cmd_i,
  output ssi_pkg::ssi_status_t          status_o,
  input  logic [ssi_pkg::POS_W-1:0]     position_i,
  output logic                          bad_position_o,
  output logic [ssi_pkg::POS_W-1:0]     new_position_o,
  output logic [ssi_pkg::ID_W-1:0]      credited_id_o,
  output logic [ssi_pkg::SCORE_W-1:0]   credited_score_o,
  output logic [ssi_pkg::ID_W-1:0]      leader_id_o,
  output logic [ssi_pkg::SCORE_W-1:0]   leader_score_o
);
  import ssi_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W =
    ($clog2(ENTRIES + 1) > POS_W) ? $clog2(ENTRIES + 1) : POS_W;

  // Table storage; valid bits stand in for the reset contents
  ssi_entry_t               mem [ENTRIES];
  logic [ENTRIES-1:0]       vld_q;

  ssi_entry_t               rd_q;
  logic                     rd_vld_q;
  logic [IDX_W-1:0]         rd_addr_q;
  logic [IDX_W-1:0]         rd_addr;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  ssi_entry_t               wr_data;

  ssi_entry_t               rd_entry;
  ssi_entry_t               cur_q, cur_d;
  logic [IDX_W-1:0]         p_q;

  logic [CNT_W-1:0]         pos_ext;
  logic [CNT_W-1:0]         pos_m1;
  logic [CNT_W-1:0]         rank1;
  logic                     pos_ok;

  logic                     bad_q;
  logic [POS_W-1:0]         res_pos_q;
  ssi_entry_t               res_q;
  ssi_entry_t               leader_q;

  // Position check
  assign pos_ext = CNT_W'(position_i);
  assign pos_m1  = pos_ext - CNT_W'(1);
  assign pos_ok  = (position_i != '0) && (pos_ext <= CNT_W'(ENTRIES));

  // Read address: requested rank, then walk toward the head
  always_comb begin
    priority if (cmd_i.start) begin
      rd_addr = IDX_W'(pos_m1);
    end else if (cmd_i.load) begin
      rd_addr = p_q - IDX_W'(1);
    end else begin
      rd_addr = p_q - IDX_W'(2);
    end
  end

  // Write port: displaced neighbor moves down, or credited entry lands
  assign wr_en   = cmd_i.shift | cmd_i.place;
  assign wr_addr = p_q;
  assign wr_data = cmd_i.shift ? rd_entry : cur_q;

  // Memory array
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Valid bits and registered read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q  <= vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Unwritten entries read as their reset contents
  always_comb begin
    if (rd_vld_q) begin
      rd_entry = rd_q;
    end else begin
      rd_entry.id    = ID_W'(rd_addr_q);
      rd_entry.score = '0;
    end
  end

  // Saturating credit
  always_comb begin
    cur_d.id    = rd_entry.id;
    cur_d.score = (rd_entry.score == SCORE_MAX) ? SCORE_MAX
                                                : rd_entry.score + SCORE_W'(1);
  end

  // Credited entry and rank pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      p_q <= IDX_W'(pos_m1);
    end else if (cmd_i.shift) begin
      p_q <= p_q - IDX_W'(1);
    end
    if (cmd_i.load) begin
      cur_q <= cur_d;
    end
  end

  // Result registers
  assign rank1 = CNT_W'(p_q) + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      bad_q     <= !pos_ok;
      res_pos_q <= '0;
      res_q     <= '0;
    end else if (cmd_i.place) begin
      res_pos_q <= rank1[POS_W-1:0];
      res_q     <= cur_q;
    end
  end

  // Leader tracks writes to the head rank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_q <= '0;
    end else if (wr_en && (wr_addr == '0)) begin
      leader_q <= wr_data;
    end
  end

  // Status
  assign status_o.pos_ok  = pos_ok;
  assign status_o.p_zero  = (p_q == '0);
  assign status_o.p_one   = (p_q == IDX_W'(1));
  assign status_o.nb_less = (rd_entry.score < cur_q.score);

  assign bad_position_o   = bad_q;
  assign new_position_o   = res_pos_q;
  assign credited_id_o    = res_q.id;
  assign credited_score_o = res_q.score;
  assign leader_id_o      = leader_q.id;
  assign leader_score_o   = leader_q.score;

endmodule

// ===== rtl/sorted_scoreboard_increment.sv =====
// Sorted scoreboard with increment. The table holds ENTRIES (identity, score) pairs in
// descending score order, starting with identities 0, 1, 2, ... (modulo 16) at score zero.
// Each input transfer names a one-based rank; that entry gains one point (held at 65535)
// and climbs past every entry above it with a strictly lower score, so it ends at the head
// of its former tie group. A rank of zero or beyond the table reports bad_position and
// leaves the table alone. One item is handled at a time. A bad position can hand off its
// result in the cycle after the input transfer. A good one is loaded, walks up past each
// rank it climbs and is then placed, skipping the compare when it starts at the head; the
// table sits in a memory with one read and one write per cycle, walked one rank per cycle.
// A new input is taken the cycle after the result transfer. The leader fields come from a
// register that follows every write to the head rank.
module sorted_scoreboard_increment #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ssi_pkg::POS_W-1:0]     position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          bad_position_o,
  output logic [ssi_pkg::POS_W-1:0]     new_position_o,
  output logic [ssi_pkg::ID_W-1:0]      credited_id_o,
  output logic [ssi_pkg::SCORE_W-1:0]   credited_score_o,
  output logic [ssi_pkg::ID_W-1:0]      leader_id_o,
  output logic [ssi_pkg::SCORE_W-1:0]   leader_score_o
);
  import ssi_pkg::*;

  ssi_cmd_t    cmd;
  ssi_status_t status;

  // Sequencer
  ssi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Table and result datapath
  ssi_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .position_i       (position_i),
    .bad_position_o   (bad_position_o),
    .new_position_o   (new_position_o),
    .credited_id_o    (credited_id_o),
    .credited_score_o (credited_score_o),
    .leader_id_o      (leader_id_o),
    .leader_score_o   (leader_score_o)
  );

endmodule
